// ===== hdl/mmu_ptw_pkg.sv =====
// ---------------------------------------------------------------------------
// MMU page table walk package
// Shared codes, widths and types for the page table walk block and checker.
// ---------------------------------------------------------------------------
package mmu_ptw_pkg;

  localparam int L1_ENTRIES = 4096;
  localparam int L1_AW      = $clog2(L1_ENTRIES);

  // request codes
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_XLATE = 2'd1;
  localparam logic [1:0] REQ_REPLY = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_OK     = 2'd0;
  localparam logic [1:0] KIND_FAULT  = 2'd1;
  localparam logic [1:0] KIND_BADPTR = 2'd2;
  localparam logic [1:0] KIND_FETCH  = 2'd3;

  // fault codes (low nibble of fault status)
  localparam logic [3:0] FSC_SECT_XLATE = 4'h5;
  localparam logic [3:0] FSC_PAGE_XLATE = 4'h7;
  localparam logic [3:0] FSC_SECT_DOM   = 4'h9;
  localparam logic [3:0] FSC_PAGE_DOM   = 4'hB;

  // first-level descriptor types
  localparam logic [1:0] L1_FAULT   = 2'd0;
  localparam logic [1:0] L1_COARSE  = 2'd1;
  localparam logic [1:0] L1_SECTION = 2'd2;
  localparam logic [1:0] L1_FINE    = 2'd3;

  // second-level descriptor types
  localparam logic [1:0] L2_FAULT = 2'd0;
  localparam logic [1:0] L2_LARGE = 2'd1;
  localparam logic [1:0] L2_SMALL = 2'd2;
  localparam logic [1:0] L2_TINY  = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MMU_ENABLE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN_ACCESS = 1'd1;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] phys_addr;
    logic [7:0]  status;
    logic [31:0] fault_addr;
  } result_t;

endpackage

// ===== hdl/mmu_page_table_walk.sv =====
// ---------------------------------------------------------------------------
// MMU page table walk
// Two-level virtual to physical translation over a local first-level table.
// ---------------------------------------------------------------------------
// The first-level table (4096 words) lives in a synchronous RAM that load
// transactions fill; every entry used must be loaded before translation is
// enabled, since the RAM has no reset. A load gives no result. For translate
// and reply transactions the acceptance cycle issues the table read and the
// next cycle decodes the entry and loads the output register; no new item
// is taken during the decode, since the RAM read is registered. A coarse or
// fine entry returns a descriptor fetch request (kind 3) and leaves a walk
// pending; the next reply transaction finishes it. Translates issued during
// a pending walk, replies with no walk pending, and request type 3 give no
// result. The result register frees the input side: a new item is taken
// while an earlier result still waits, and the decode cycle holds only if
// the result register is still full. Configuration writes are always ready.
module mmu_page_table_walk (
  input  logic                              clk,
  input  logic                              rst,
  // input transactions
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        req_type,
  input  logic [31:0]                       vaddr,
  input  logic [mmu_ptw_pkg::L1_AW-1:0]     table_index,
  input  logic [31:0]                       table_word,
  input  logic                              reply_ok,
  // result transactions
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        result_kind,
  output logic [31:0]                       phys_addr,
  output logic [7:0]                        fault_status,
  output logic [31:0]                       fault_address,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mmu_ptw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                       cfg_data
);

  import mmu_ptw_pkg::*;

  // control
  state_t state, state_next;

  // configuration registers
  logic        mmu_enable;
  logic [31:0] domain_access;

  // walk state
  logic        walk_pending, walk_pending_next;
  logic [31:0] pending_vaddr;
  logic [3:0]  pending_domain;
  logic        pend_load;

  // captured transaction
  logic [1:0]  cur_type;
  logic [31:0] cur_vaddr;
  logic [31:0] cur_word;
  logic        cur_ok;

  // table RAM
  logic             ram_wr_en;
  logic [L1_AW-1:0] ram_rd_addr;
  logic [31:0]      entry;

  // decode
  result_t     res;
  logic        res_valid;
  logic        slot_free;
  logic        out_load;
  logic [3:0]  dom;
  logic [3:0]  reply_dom;
  logic        dom_ok;
  logic        reply_dom_ok;

  logic        in_accept;

  assign in_ready  = (state == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Load writes straight into the table; the read address follows the input
  // while idle and holds the captured address while decoding.
  assign ram_wr_en   = in_accept && (req_type == REQ_LOAD);
  assign ram_rd_addr = (state == ST_IDLE) ? vaddr[31:20] : cur_vaddr[31:20];

  mmu_ptw_ram #(
    .WIDTH(32),
    .DEPTH(L1_ENTRIES)
  ) u_l1_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(table_index),
    .wr_data(table_word),
    .rd_addr(ram_rd_addr),
    .rd_data(entry)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      mmu_enable    <= 1'b0;
      domain_access <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MMU_ENABLE:    mmu_enable    <= cfg_data[0];
        CFG_DOMAIN_ACCESS: domain_access <= cfg_data;
        default: ;
      endcase
    end
  end

  // capture translate and reply transactions for the decode cycle
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cur_type  <= req_type;
      cur_vaddr <= vaddr;
      cur_word  <= table_word;
      cur_ok    <= reply_ok;
    end
  end

  // domain checks: bit zero of each two-bit field grants access
  assign dom          = entry[8:5];
  assign reply_dom    = pending_domain;
  assign dom_ok       = domain_access[{dom, 1'b0}];
  assign reply_dom_ok = domain_access[{reply_dom, 1'b0}];

  // decode the captured transaction against the table entry
  always_comb begin
    res               = '0;
    res_valid         = 1'b0;
    walk_pending_next = walk_pending;
    pend_load         = 1'b0;
    if (cur_type == REQ_XLATE) begin
      if (!walk_pending) begin
        res_valid = 1'b1;
        if (!mmu_enable) begin
          res.kind      = KIND_OK;
          res.phys_addr = cur_vaddr;
        end else begin
          unique case (entry[1:0])
            L1_FAULT: begin
              res.kind       = KIND_FAULT;
              res.status     = {dom, FSC_SECT_XLATE};
              res.fault_addr = cur_vaddr;
            end
            L1_SECTION: begin
              if (!dom_ok) begin
                res.kind       = KIND_FAULT;
                res.status     = {dom, FSC_SECT_DOM};
                res.fault_addr = cur_vaddr;
              end else begin
                res.kind      = KIND_OK;
                res.phys_addr = {entry[31:20], cur_vaddr[19:0]};
              end
            end
            L1_COARSE: begin
              res.kind          = KIND_FETCH;
              res.phys_addr     = {entry[31:10], cur_vaddr[19:12], 2'b00};
              walk_pending_next = 1'b1;
              pend_load         = 1'b1;
            end
            L1_FINE: begin
              res.kind          = KIND_FETCH;
              res.phys_addr     = {entry[31:12], cur_vaddr[19:10], 2'b00};
              walk_pending_next = 1'b1;
              pend_load         = 1'b1;
            end
            default: ;
          endcase
        end
      end
    end else if (cur_type == REQ_REPLY) begin
      if (walk_pending) begin
        res_valid         = 1'b1;
        walk_pending_next = 1'b0;
        res.fault_addr    = pending_vaddr;
        if (!cur_ok) begin
          res.kind = KIND_BADPTR;
        end else if (cur_word[1:0] == L2_FAULT) begin
          res.kind   = KIND_FAULT;
          res.status = {reply_dom, FSC_PAGE_XLATE};
        end else if (!reply_dom_ok) begin
          res.kind   = KIND_FAULT;
          res.status = {reply_dom, FSC_PAGE_DOM};
        end else begin
          res.kind       = KIND_OK;
          res.fault_addr = '0;
          unique case (cur_word[1:0])
            L2_LARGE: res.phys_addr = {cur_word[31:16], pending_vaddr[15:0]};
            L2_SMALL: res.phys_addr = {cur_word[31:12], pending_vaddr[11:0]};
            L2_TINY:  res.phys_addr = {cur_word[31:10], pending_vaddr[9:0]};
            default:  res.phys_addr = '0;
          endcase
        end
      end
    end
  end

  assign slot_free = !out_valid || out_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state: go to decode for translate and reply, hold decode while the
  // result register is still full
  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_accept && (req_type == REQ_XLATE || req_type == REQ_REPLY)) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!res_valid) begin
          state_next = ST_IDLE;
        end else if (slot_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // walk state advances only when the decode result is committed
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_pending   <= 1'b0;
      pending_vaddr  <= '0;
      pending_domain <= '0;
    end else if (out_load) begin
      walk_pending <= walk_pending_next;
      if (pend_load) begin
        pending_vaddr  <= cur_vaddr;
        pending_domain <= dom;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_kind   <= res.kind;
      phys_addr     <= res.phys_addr;
      fault_status  <= res.status;
      fault_address <= res.fault_addr;
    end
  end

endmodule

// ===== hdl/mmu_ptw_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module mmu_ptw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/mmu_ptw_chk.sv =====
// ---------------------------------------------------------------------------
// MMU page table walk checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
module mmu_ptw_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  req_type,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  result_kind,
  input logic [31:0] phys_addr,
  input logic [7:0]  fault_status,
  input logic [31:0] fault_address
);

  import mmu_ptw_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(phys_addr))
    else $error("stalled result changed");

  // translate and reply transactions occupy the block for a decode cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (req_type == REQ_XLATE || req_type == REQ_REPLY) |=> !in_ready)
    else $error("input taken during decode cycle");

  // translated results and fetch requests carry no fault information
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == KIND_OK || result_kind == KIND_FETCH)
      |-> fault_status == 8'h00 && fault_address == 32'h0)
    else $error("fault fields set on non-fault result");

  // faults carry a known fault code and no physical address
  assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_FAULT
      |-> phys_addr == 32'h0 &&
          (fault_status[3:0] == FSC_SECT_XLATE || fault_status[3:0] == FSC_PAGE_XLATE ||
           fault_status[3:0] == FSC_SECT_DOM || fault_status[3:0] == FSC_PAGE_DOM))
    else $error("malformed fault result");

  // a bad table pointer reports only the address
  assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_BADPTR |-> phys_addr == 32'h0 && fault_status == 8'h00)
    else $error("malformed bad pointer result");

endmodule

bind mmu_page_table_walk mmu_ptw_chk u_mmu_ptw_chk (.*);
